/* rtl/qad_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and the transition table of the quadrature angle decoder.
package qad_pkg;

   // Default angle width and counts-per-revolution register layout.
   localparam int ANGLE_WIDTH_DEFAULT = 12;
   localparam int CPR_WIDTH           = 13;
   localparam int CPR_RESET           = 448;

   // Event kind carried on the request tuser.
   typedef enum logic {
      OP_QUAD = 1'b0,
      OP_REF  = 1'b1
   } op_type;

   // Step classification.
   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_CW   = 2'd1,
      DIR_CCW  = 2'd2,
      DIR_ERR  = 2'd3
   } dir_type;

   // Classify one transition; index is {prev_a, prev_b, cur_a, cur_b}.
   function automatic dir_type step_lookup(input logic [3:0] idx);
      dir_type d;
      case (idx)
         4'h0:    d = DIR_NONE;
         4'h1:    d = DIR_CW;
         4'h2:    d = DIR_CCW;
         4'h3:    d = DIR_ERR;
         4'h4:    d = DIR_CCW;
         4'h5:    d = DIR_NONE;
         4'h6:    d = DIR_ERR;
         4'h7:    d = DIR_CW;
         4'h8:    d = DIR_CW;
         4'h9:    d = DIR_ERR;
         4'hA:    d = DIR_NONE;
         4'hB:    d = DIR_CCW;
         4'hC:    d = DIR_ERR;
         4'hD:    d = DIR_CCW;
         4'hE:    d = DIR_CW;
         default: d = DIR_NONE;
      endcase
      return d;
   endfunction

endpackage

/* rtl/quadrature_angle_decoder_unit.sv */
`timescale 1ns / 1ps
// Quadrature angle decoder: x4 transition decode with a wrapping angle count.
//
// Each request transfer is one event: tuser 0 is a pin sample (tdata bit 0 is
// channel A, bit 1 channel B), tuser 1 is a reference pulse that captures the
// current angle. Every event yields exactly one response transfer carrying
// the angle, the last reference capture and the last step classification
// (none, clockwise, counter-clockwise, error when both pins changed). The
// angle wraps at counts_per_rev, clamped to [2, 2^ANGLE_WIDTH]. The first pin
// sample after reset only records the pins. Throughput is one event per
// clock while responses are accepted; a stalled response holds the input
// register. The request transfer loads the input register; from there one
// pass of table lookup and wrapping increment moves the event into the
// decoder state, which doubles as the response register, so response valid
// rises once the event leaves the input register. Write counts_per_rev only
// while no events are in flight; csr_ready is always high.
module quadrature_angle_decoder_unit #(
   parameter  int ANGLE_WIDTH = qad_pkg::ANGLE_WIDTH_DEFAULT,
   localparam int RSP_BITS    = 2 * ANGLE_WIDTH + 2,
   localparam int RSP_WIDTH   = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [0] pin_a, [1] pin_b, rest zero
   input  logic [0:0]                    req_tuser,   // [0] opcode
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_WIDTH-1:0]          rsp_tdata,   // angle, ref_angle, direction, zero pad
   // configuration write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [qad_pkg::CPR_WIDTH-1:0] csr_data     // counts_per_rev
);

   localparam int MOD_WIDTH = ANGLE_WIDTH + 1;
   localparam int CMP_WIDTH = (qad_pkg::CPR_WIDTH > MOD_WIDTH) ? qad_pkg::CPR_WIDTH : MOD_WIDTH;
   localparam int MOD_TOP   = 2 ** ANGLE_WIDTH;
   localparam int MOD_RESET = (qad_pkg::CPR_RESET < 2) ? 2 :
                              ((qad_pkg::CPR_RESET > MOD_TOP) ? MOD_TOP : qad_pkg::CPR_RESET);

   // Effective modulus, clamped when the register is written.
   logic [MOD_WIDTH-1:0] mod_ff;
   logic [CMP_WIDTH-1:0] cpr_ext;
   logic [CMP_WIDTH-1:0] top_ext;
   logic [CMP_WIDTH-1:0] mod_clamp;

   // Input register stage.
   logic             s1_valid_ff;
   qad_pkg::op_type  s1_opcode_ff;
   logic [1:0]       s1_pins_ff;
   logic             s1_advance;

   // Decoder state, also the response payload.
   logic                   rsp_valid_ff;
   logic [1:0]             prev_pins_ff,  prev_pins_in;
   logic                   primed_ff,     primed_in;
   logic [ANGLE_WIDTH-1:0] angle_ff,      angle_in;
   logic [ANGLE_WIDTH-1:0] ref_angle_ff,  ref_angle_in;
   qad_pkg::dir_type       last_dir_ff,   last_dir_in;

   assign csr_ready = 1'b1;

   assign cpr_ext   = CMP_WIDTH'(csr_data);
   assign top_ext   = CMP_WIDTH'(MOD_TOP);
   assign mod_clamp = (cpr_ext < CMP_WIDTH'(2)) ? CMP_WIDTH'(2) :
                      ((cpr_ext > top_ext) ? top_ext : cpr_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MOD_WIDTH'(MOD_RESET);
      end else if (csr_valid && csr_ready) begin
         mod_ff <= mod_clamp[MOD_WIDTH-1:0];
      end
   end

   // Advance the input stage whenever the response slot is free or draining.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_opcode_ff <= qad_pkg::op_type'(req_tuser[0]);
         s1_pins_ff   <= {req_tdata[0], req_tdata[1]};
      end
   end

   qad_step_logic #(
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_step (
      .opcode       (s1_opcode_ff),
      .pins         (s1_pins_ff),
      .modulus      (mod_ff),
      .prev_pins    (prev_pins_ff),
      .primed       (primed_ff),
      .angle        (angle_ff),
      .ref_angle    (ref_angle_ff),
      .last_dir     (last_dir_ff),
      .prev_pins_in (prev_pins_in),
      .primed_in    (primed_in),
      .angle_in     (angle_in),
      .ref_angle_in (ref_angle_in),
      .last_dir_in  (last_dir_in)
   );

   // Update state only when the event moves into the response slot, so a
   // stalled response holds its payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_pins_ff <= '0;
         primed_ff    <= 1'b0;
         angle_ff     <= '0;
         ref_angle_ff <= '0;
         last_dir_ff  <= qad_pkg::DIR_NONE;
      end else begin
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
            prev_pins_ff <= prev_pins_in;
            primed_ff    <= primed_in;
            angle_ff     <= angle_in;
            ref_angle_ff <= ref_angle_in;
            last_dir_ff  <= last_dir_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_WIDTH'({last_dir_ff, ref_angle_ff, angle_ff});

   // A reference event captures the angle as it stood.
   assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_opcode_ff == qad_pkg::OP_REF) |=> ref_angle_ff == $past(angle_ff))
      else $error("reference capture does not match the prior angle");

   // The priming sample never moves the angle.
   assert property (@(posedge clock) disable iff (reset)
      (s1_advance && !primed_ff) |=> angle_ff == $past(angle_ff))
      else $error("angle moved before priming");

   // The angle moves only on a classified single-pin step.
   assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> (last_dir_ff == qad_pkg::DIR_CW || last_dir_ff == qad_pkg::DIR_CCW ||
                      angle_ff == $past(angle_ff)))
      else $error("angle moved without a step");

   // An empty input stage always takes a transfer.
   assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("input stage empty but not ready");

endmodule

/* rtl/qad_step_logic.sv */
`timescale 1ns / 1ps
// Next-state logic for one decoder event: capture a reference, or classify, step and wrap the angle.
module qad_step_logic #(
   parameter int ANGLE_WIDTH = qad_pkg::ANGLE_WIDTH_DEFAULT
) (
   input  qad_pkg::op_type         opcode,
   input  logic [1:0]              pins,
   input  logic [ANGLE_WIDTH:0]    modulus,
   input  logic [1:0]              prev_pins,
   input  logic                    primed,
   input  logic [ANGLE_WIDTH-1:0]  angle,
   input  logic [ANGLE_WIDTH-1:0]  ref_angle,
   input  qad_pkg::dir_type        last_dir,
   output logic [1:0]              prev_pins_in,
   output logic                    primed_in,
   output logic [ANGLE_WIDTH-1:0]  angle_in,
   output logic [ANGLE_WIDTH-1:0]  ref_angle_in,
   output qad_pkg::dir_type        last_dir_in
);

   logic [ANGLE_WIDTH:0] angle_ext;
   logic [ANGLE_WIDTH:0] angle_inc;
   logic [ANGLE_WIDTH:0] mod_less1;
   qad_pkg::dir_type     dir;

   assign angle_ext = {1'b0, angle};
   assign angle_inc = angle_ext + {{ANGLE_WIDTH{1'b0}}, 1'b1};
   assign mod_less1 = modulus - {{ANGLE_WIDTH{1'b0}}, 1'b1};
   assign dir       = qad_pkg::step_lookup({prev_pins, pins});

   always_comb begin
      prev_pins_in = prev_pins;
      primed_in    = primed;
      angle_in     = angle;
      ref_angle_in = ref_angle;
      last_dir_in  = last_dir;
      case (opcode)
         qad_pkg::OP_REF: begin
            ref_angle_in = angle;
         end
         default: begin
            prev_pins_in = pins;
            primed_in    = 1'b1;
            if (primed) begin
               last_dir_in = dir;
               case (dir)
                  qad_pkg::DIR_CW: begin
                     angle_in = (angle_inc >= modulus) ? '0 : angle_inc[ANGLE_WIDTH-1:0];
                  end
                  qad_pkg::DIR_CCW: begin
                     if (angle == '0 || angle_ext >= modulus) begin
                        angle_in = mod_less1[ANGLE_WIDTH-1:0];
                     end else begin
                        angle_in = angle - {{(ANGLE_WIDTH-1){1'b0}}, 1'b1};
                     end
                  end
                  default: begin
                     angle_in = angle;
                  end
               endcase
            end
         end
      endcase
   end

endmodule
